// ===== hdl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

  // Built number of entries, one cell each
  localparam int DEPTH    = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CAP_W    = 5;
  localparam int OCC_W    = 5;
  localparam int CMP_W    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int CAP_RESET = 16;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_POP_FRONT  = 2'd1,
    ACT_PUSH_REAR  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cell command: shift toward rear, shift toward front, load the push word
  typedef struct packed {
    logic shr;
    logic shl;
    logic wr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/dq_in_if.sv =====
`default_nettype none

interface dq_in_if
  import dq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/dq_out_if.sv =====
`default_nettype none

interface dq_out_if
  import dq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [DATA_W-1:0] popped_value;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output popped_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input popped_value, input occupancy,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/dq_cfg_if.sv =====
`default_nettype none

interface dq_cfg_if
  import dq_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words.
// Channels: in_ch carries an action (push front, pop front, push rear, pop rear)
// and a push word; out_ch returns one result per action: status (done, full,
// empty), the popped word (zero unless a pop succeeded) and the occupancy after
// the action. cfg_ch writes the capacity register (its use clipped to built depth).
// Storage is a row of cells, front entry in cell 0. A front push shifts every
// cell one place toward the rear, a front pop shifts every cell toward the
// front; rear pushes write the cell at the count, rear pops read the one before.
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one action per cycle while out_ch is taken; the output register
// is the only stage, so in_ch.ready drops while an untaken result is held.
// Reset (rst_n low, synchronous): queue empty, capacity 16, no result pending.
// Cell contents are not cleared. When the receiver stalls the result holds
// and no new action is taken until it is.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch,
  dq_cfg_if.sink    cfg_ch
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;
  logic [OCC_W-1:0]  occ_r;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  limit;
  logic              do_shr, do_shl, do_wr;
  logic [IDX_W-1:0]  tail_idx;
  logic [CNT_W-1:0]  tail_cnt;
  logic [DATA_W-1:0] cell_data [DEPTH];

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Effective capacity: register value clipped to the cell count
  assign cap_ext  = CMP_W'(cap_r);
  assign limit    = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign is_full  = (CMP_W'(count_r) >= limit);
  assign is_empty = (count_r == '0);
  assign tail_cnt = count_r - CNT_W'(1);
  assign tail_idx = tail_cnt[IDX_W-1:0];

  // Action decode
  always_comb begin
    do_shr     = 1'b0;
    do_shl     = 1'b0;
    do_wr      = 1'b0;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    popped_nxt = '0;
    unique case (in_ch.action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          do_shr    = accept && (in_ch.action == ACT_PUSH_FRONT);
          do_wr     = accept && (in_ch.action == ACT_PUSH_REAR);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = cell_data[0];
          do_shl     = accept;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      ACT_POP_REAR: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = cell_data[tail_idx];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t        ctrl;
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;

    assign ctrl.shr = do_shr;
    assign ctrl.shl = do_shl;
    assign ctrl.wr  = do_wr && (count_r == CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_d = in_ch.value;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .wdata      (in_ch.value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i])
    );
  end

  // Control state: count, capacity, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_W'(CAP_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cap_r <= cfg_ch.data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.occupancy    = occ_r;

endmodule

`default_nettype wire

// ===== hdl/dq_cell.sv =====
`default_nettype none

module dq_cell
  import dq_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [DATA_W-1:0] left_data,   // neighbor toward the front
  input  wire logic [DATA_W-1:0] right_data,  // neighbor toward the rear
  output logic      [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Next word: take from a neighbor on a shift, or the push word on a rear write
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shr) begin
      data_nxt = left_data;
    end else if (ctrl.shl) begin
      data_nxt = right_data;
    end else if (ctrl.wr) begin
      data_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== hdl/dq_checker.sv =====
`default_nettype none

module dq_checker
  import dq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        status,
  input wire logic [DATA_W-1:0] popped_value,
  input wire logic [OCC_W-1:0]  occupancy
);

  // Stalled result holds its popped word and occupancy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(occupancy))
    else $error("result changed while stalled");

  // Every transfer in yields a result next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  // Nothing pending right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Refused pop: queue empty and no word
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY) |-> (occupancy == '0) && (popped_value == '0))
    else $error("empty status inconsistent");

  // Refused push: no word returned
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FULL) |-> (popped_value == '0))
    else $error("full status inconsistent");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .popped_value (out_ch.popped_value),
  .occupancy    (out_ch.occupancy)
);

`default_nettype wire

// ===== tb/sv/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps

module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 200;
  localparam int RAND_PER_CAP = 145;

  typedef struct {
    action_t                  action;
    logic signed [DATA_W-1:0] value;
  } deque_action_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] popped_value;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dq_in_if  in_if ();
  dq_out_if out_if ();
  dq_cfg_if cfg_if ();

  double_ended_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow deque state
  logic signed [DATA_W-1:0] shadow_store [DEPTH];
  logic [IDX_W-1:0]         shadow_head;
  logic [CNT_W-1:0]         shadow_count;
  logic [CAP_W-1:0]         shadow_cap;

  deque_action_t pending_actions [$];
  deque_result_t expected_results [$];

  int error_count;
  int cycle_count;
  int actions_sent;
  int cap_writes;
  int done_seen, full_seen, empty_seen;

  // Sender burst state
  int            burst_left;
  int            gap_left;
  deque_action_t next_action;

  // Receiver stall state
  int hold_req;
  int hold_ack;
  int hold_left;
  int stall_mode;
  int mode_left;
  int pattern_step;

  deque_result_t got_want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Known values on every block input from time zero
  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.action  = ACT_PUSH_FRONT;
    in_if.value   = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
  end

  task automatic note_error(input string msg);
    if (error_count < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Applies one action to the shadow deque, returns the result it should give
  function automatic deque_result_t deque_apply(input action_t act,
                                                input logic signed [DATA_W-1:0] word);
    deque_result_t r;
    int room;
    int pos;
    r.status       = ST_DONE;
    r.popped_value = '0;
    room = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (int'(shadow_count) >= room) begin
          r.status = ST_FULL;
        end else if (act == ACT_PUSH_FRONT) begin
          shadow_head = (shadow_head == 0) ? IDX_W'(DEPTH - 1) : shadow_head - 1'b1;
          shadow_store[shadow_head] = word;
          shadow_count++;
        end else begin
          pos = (int'(shadow_head) + int'(shadow_count)) % DEPTH;
          shadow_store[pos] = word;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (act == ACT_POP_FRONT) begin
          r.popped_value = shadow_store[shadow_head];
          shadow_head = (int'(shadow_head) == DEPTH - 1) ? '0 : shadow_head + 1'b1;
          shadow_count--;
        end else begin
          pos = (int'(shadow_head) + int'(shadow_count) - 1) % DEPTH;
          r.popped_value = shadow_store[pos];
          shadow_count--;
        end
      end
    endcase
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // Driver: bursts of transfers with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(deque_apply(in_if.action, in_if.value));
        actions_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (pending_actions.size() == 0) begin
          in_if.valid <= 1'b0;
        end else begin
          next_action = pending_actions.pop_front();
          in_if.valid  <= 1'b1;
          in_if.action <= next_action.action;
          in_if.value  <= next_action.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    = 0;
      stall_mode   = 0;
      mode_left    = 0;
      pattern_step = 0;
    end else begin
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      pattern_step++;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= ($urandom_range(0, 3) != 0);
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= (pattern_step % 5 != 0);
        endcase
      end
    end
  end

  // Monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("result with nothing expected: status %0d occ %0d",
                             out_if.status, out_if.occupancy));
      end else begin
        got_want = expected_results.pop_front();
        if (out_if.status !== got_want.status)
          note_error($sformatf("status got %0d want %0d", out_if.status, got_want.status));
        if (out_if.popped_value !== got_want.popped_value)
          note_error($sformatf("popped_value got %h want %h",
                               out_if.popped_value, got_want.popped_value));
        if (out_if.occupancy !== got_want.occupancy)
          note_error($sformatf("occupancy got %0d want %0d",
                               out_if.occupancy, got_want.occupancy));
        case (got_want.status)
          ST_DONE:  done_seen++;
          ST_FULL:  full_seen++;
          default:  empty_seen++;
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_action(input action_t act, input logic signed [DATA_W-1:0] word);
    deque_action_t a;
    a.action = act;
    a.value  = word;
    pending_actions.push_back(a);
  endtask

  // Sender pause: every action accepted and every result taken
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_actions.size() != 0 || in_if.valid || expected_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    @(posedge clk);
    while (!(cfg_if.valid && cfg_if.ready)) @(posedge clk);
    shadow_cap = cfg_if.data;
    cap_writes++;
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly fill and drain runs at the current capacity, some random noise
  task automatic add_random_traffic(input int n);
    int left;
    int run;
    int room;
    int kind;
    left = n;
    room = (int'(shadow_cap) > DEPTH) ? DEPTH : int'(shadow_cap);
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      run  = (kind < 8) ? room + $urandom_range(0, 3) : $urandom_range(1, 10);
      if (run > left) run = left;
      if (run == 0) run = 1;
      repeat (run) begin
        if (kind < 4)
          add_action($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, rand_word());
        else if (kind < 8)
          add_action($urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT, rand_word());
        else
          add_action(action_t'($urandom_range(0, 3)), rand_word());
      end
      left -= run;
    end
  endtask

  // Stimulus sequence
  initial begin
    logic [CAP_W-1:0] cap_list [9];
    error_count  = 0;
    actions_sent = 0;
    cap_writes   = 0;
    done_seen    = 0;
    full_seen    = 0;
    empty_seen   = 0;
    hold_req     = 0;
    hold_ack     = 0;
    shadow_head  = '0;
    shadow_count = '0;
    shadow_cap   = CAP_W'(CAP_RESET);
    foreach (shadow_store[i]) shadow_store[i] = '0;
    cap_list = '{5'd16, 5'd31, 5'd3, 5'd17, 5'd1, 5'd0, 5'd9, 5'd0, 5'd16};
    cap_list[7] = CAP_W'($urandom_range(0, 31));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty pops, extreme words through both ends at reset capacity
    add_action(ACT_POP_FRONT, 32'sh1234_5678);
    add_action(ACT_POP_REAR, -32'sd1);
    add_action(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
    add_action(ACT_PUSH_REAR, 32'sh8000_0000);
    add_action(ACT_PUSH_FRONT, -32'sd1);
    add_action(ACT_PUSH_REAR, '0);
    add_action(ACT_POP_REAR, '0);
    add_action(ACT_POP_FRONT, '0);
    add_action(ACT_POP_REAR, '0);
    add_action(ACT_POP_FRONT, '0);
    add_action(ACT_POP_REAR, '0);
    add_action(ACT_PUSH_REAR, rand_word());
    add_action(ACT_PUSH_FRONT, rand_word());
    add_action(ACT_PUSH_REAR, rand_word());

    // Capacity lowered below occupancy: entries stay, pushes refused until it drops below
    write_capacity(5'd2);
    add_action(ACT_PUSH_FRONT, rand_word());
    add_action(ACT_POP_FRONT, '0);
    add_action(ACT_PUSH_REAR, rand_word());
    add_action(ACT_POP_REAR, '0);
    add_action(ACT_PUSH_FRONT, rand_word());

    // Zero capacity refuses every push
    write_capacity(5'd0);
    add_action(ACT_PUSH_REAR, rand_word());
    add_action(ACT_POP_REAR, '0);
    add_action(ACT_POP_FRONT, '0);
    add_action(ACT_PUSH_FRONT, rand_word());

    // Single entry
    write_capacity(5'd1);
    add_action(ACT_PUSH_FRONT, rand_word());
    add_action(ACT_PUSH_REAR, rand_word());
    add_action(ACT_POP_REAR, '0);

    // Random phases over a spread of capacities, queue contents carried over
    foreach (cap_list[p]) begin
      write_capacity(cap_list[p]);
      add_random_traffic(RAND_PER_CAP);
      if (p == 1 || p == 6) hold_req++;
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_results.size()));

    $display("Covered %0d actions over %0d capacity writes (zero to above depth)",
             actions_sent, cap_writes);
    $display("Results: %0d done, %0d refused full, %0d refused empty",
             done_seen, full_seen, empty_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/dq_pkg.sv
hdl/dq_in_if.sv
hdl/dq_out_if.sv
hdl/dq_cfg_if.sv
hdl/dq_cell.sv
hdl/double_ended_queue.sv
hdl/dq_checker.sv
tb/sv/tb_double_ended_queue.sv
